// ----- rtl/core/ccb_pkg.sv -----
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types and character constants for the C comment blanker.
// ----------------------------------------------------------------------------
package ccb_pkg;

    // Character codes
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Most output beats one input beat can cause
    localparam int RES_DEPTH = 3;
    localparam int CNT_W     = 2;

    // Scanner mode
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_BSTAR  = 3'd4
    } mode_t;

endpackage

// ----- rtl/core/c_comment_blanker_unit.sv -----
// ----------------------------------------------------------------------------
// c_comment_blanker_unit
// Streaming C comment blanker, one source byte per input beat.
// ----------------------------------------------------------------------------
// Source bytes enter on in_char/in_last and leave on out_char/out_last. Every
// byte of a // or /* */ comment becomes a space, except newlines, which pass
// through; the comment delimiters themselves are dropped. A '/' is held for
// one byte of lookahead, so it appears only once the next byte is known.
// String literals are not tracked. The beat marked in_last flushes any held
// byte and is followed by a zero byte with out_last set; the scanner then
// returns to normal text. Throughput is one input beat per cycle as long as
// each byte gives at most one output beat and out_ready stays high; a byte
// that gives two or three output beats (a '/' followed by a plain byte, a
// held '*' followed by anything but '/' or '*' in a block, or a final byte
// that leaves output ahead of the terminator) stalls the input, because the
// three-entry result buffer drains through the single output port one beat
// per cycle. From input beat to first output beat a byte passes the input
// register and then the result buffer. A byte that gives no output (a held
// '/' or comment delimiter) leaves the result buffer empty.
// ----------------------------------------------------------------------------
module c_comment_blanker_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last
);

    localparam int Depth = ccb_pkg::RES_DEPTH;
    localparam int CntW  = ccb_pkg::CNT_W;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Scanner mode
    ccb_pkg::mode_t mode_reg;
    ccb_pkg::mode_t mode_next;

    // Result buffer: slot 0 is the head shown on the output port
    logic [7:0]      res_char_reg [Depth];
    logic            res_last_reg [Depth];
    logic [CntW-1:0] res_cnt_reg;

    // Results of the byte held in the input register
    logic [7:0]      r_char [Depth];
    logic            r_last [Depth];
    logic [CntW-1:0] r_n;

    logic out_pop;
    logic buf_free;
    logic proc;

    assign out_valid = (res_cnt_reg != '0);
    assign out_char  = res_char_reg[0];
    assign out_last  = res_last_reg[0];
    assign out_pop   = out_valid && out_ready;

    // Buffer is empty after this cycle's pop, so a new set may load
    assign buf_free = (res_cnt_reg == '0)
                   || ((res_cnt_reg == CntW'(1)) && out_ready);
    assign proc     = in_valid_reg && buf_free;
    assign in_ready = !in_valid_reg || proc;

    // Scan one byte: up to three results and the next mode
    always_comb
    begin
        logic [7:0] c;
        c         = in_char_reg;
        r_n       = '0;
        mode_next = mode_reg;
        for (int i = 0; i < Depth; i++)
        begin
            r_char[i] = ccb_pkg::CH_NUL;
            r_last[i] = 1'b0;
        end

        unique case (mode_reg)
            ccb_pkg::MODE_SLASH:
            begin
                if (c == ccb_pkg::CH_SLASH)
                begin
                    mode_next = ccb_pkg::MODE_LINE;
                end
                else if (c == ccb_pkg::CH_STAR)
                begin
                    mode_next = ccb_pkg::MODE_BLOCK;
                end
                else
                begin
                    // held slash goes out, new byte seen as normal text
                    r_char[r_n] = ccb_pkg::CH_SLASH;
                    r_n         = r_n + CntW'(1);
                    mode_next   = ccb_pkg::MODE_NORMAL;
                    r_char[r_n] = c;
                    r_n         = r_n + CntW'(1);
                end
            end
            ccb_pkg::MODE_LINE:
            begin
                if (c == ccb_pkg::CH_NL)
                begin
                    r_char[r_n] = ccb_pkg::CH_NL;
                    mode_next   = ccb_pkg::MODE_NORMAL;
                end
                else
                begin
                    r_char[r_n] = ccb_pkg::CH_SPACE;
                end
                r_n = r_n + CntW'(1);
            end
            ccb_pkg::MODE_BLOCK:
            begin
                if (c == ccb_pkg::CH_STAR)
                begin
                    mode_next = ccb_pkg::MODE_BSTAR;
                end
                else
                begin
                    r_char[r_n] = (c == ccb_pkg::CH_NL) ? ccb_pkg::CH_NL
                                                        : ccb_pkg::CH_SPACE;
                    r_n         = r_n + CntW'(1);
                end
            end
            ccb_pkg::MODE_BSTAR:
            begin
                if (c == ccb_pkg::CH_SLASH)
                begin
                    mode_next = ccb_pkg::MODE_NORMAL;
                end
                else
                begin
                    // held star becomes a space, new byte seen as block text
                    r_char[r_n] = ccb_pkg::CH_SPACE;
                    r_n         = r_n + CntW'(1);
                    if (c == ccb_pkg::CH_STAR)
                    begin
                        mode_next = ccb_pkg::MODE_BSTAR;
                    end
                    else
                    begin
                        mode_next   = ccb_pkg::MODE_BLOCK;
                        r_char[r_n] = (c == ccb_pkg::CH_NL) ? ccb_pkg::CH_NL
                                                            : ccb_pkg::CH_SPACE;
                        r_n         = r_n + CntW'(1);
                    end
                end
            end
            default:
            begin
                if (c == ccb_pkg::CH_SLASH)
                begin
                    mode_next = ccb_pkg::MODE_SLASH;
                end
                else
                begin
                    mode_next   = ccb_pkg::MODE_NORMAL;
                    r_char[r_n] = c;
                    r_n         = r_n + CntW'(1);
                end
            end
        endcase

        // End of stream: flush held byte, then the terminator
        if (in_last_reg)
        begin
            if (mode_next == ccb_pkg::MODE_SLASH)
            begin
                r_char[r_n] = ccb_pkg::CH_SLASH;
                r_n         = r_n + CntW'(1);
            end
            else if (mode_next == ccb_pkg::MODE_BSTAR)
            begin
                r_char[r_n] = ccb_pkg::CH_SPACE;
                r_n         = r_n + CntW'(1);
            end
            r_char[r_n] = ccb_pkg::CH_NUL;
            r_last[r_n] = 1'b1;
            r_n         = r_n + CntW'(1);
            mode_next   = ccb_pkg::MODE_NORMAL;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= ccb_pkg::MODE_NORMAL;
            res_cnt_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (proc)
            begin
                mode_reg    <= mode_next;
                res_cnt_reg <= r_n;
            end
            else if (out_pop)
            begin
                res_cnt_reg <= res_cnt_reg - CntW'(1);
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_char_reg <= in_char;
            in_last_reg <= in_last;
        end
        if (proc)
        begin
            for (int i = 0; i < Depth; i++)
            begin
                res_char_reg[i] <= r_char[i];
                res_last_reg[i] <= r_last[i];
            end
        end
        else if (out_pop)
        begin
            for (int i = 0; i < Depth - 1; i++)
            begin
                res_char_reg[i] <= res_char_reg[i+1];
                res_last_reg[i] <= res_last_reg[i+1];
            end
        end
    end

`ifndef SYNTHESIS
    // Terminator beat always carries a zero byte
    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> (out_char == ccb_pkg::CH_NUL))
        else $error("terminator beat carries nonzero byte");

    // Scanner is back in normal text when the terminator leaves
    a_last_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_pop && out_last) |-> (mode_reg == ccb_pkg::MODE_NORMAL))
        else $error("mode not normal at terminator");

    // A stalled byte in the input register is kept
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc) |=> (in_valid_reg && $stable(in_char_reg)
                                     && $stable(in_last_reg)))
        else $error("stalled input byte lost");

    // A new result set never overwrites unsent results
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && (res_cnt_reg != '0)) |-> out_pop)
        else $error("result buffer overwritten");

    // Loading a byte that gives nothing leaves the buffer empty
    a_empty_load: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && (r_n == '0)) |=> !out_valid)
        else $error("stale results after empty load");
`endif

endmodule
